/* design/pdh_pkg.sv */
`timescale 1ns / 1ps

package pdh_pkg;

   localparam int MulSteps = 8;
   localparam int DivSteps = 18;
   localparam int CntWidth = 5;
   localparam int ProdWidth = 32;
   localparam int DividendWidth = 36;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 16;

   localparam logic [CsrIndexWidth-1:0] RegForwardSpeed = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegMaxAngle     = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegPropGain     = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegDerivGain    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegWallSetpoint = 3'd4;

   localparam logic [14:0] ForwardSpeedReset = 15'd1229;
   localparam logic [14:0] MaxAngleReset     = 15'd3277;
   localparam logic [15:0] PropGainReset     = 16'd3277;
   localparam logic [15:0] DerivGainReset    = 16'd13156;
   localparam logic [14:0] WallSetpointReset = 15'd1229;

   typedef struct packed {
      logic signed [15:0] error_value;
      logic [14:0]        wall_distance;
      logic [15:0]        elapsed_time;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] turn_command;
      logic [14:0]        speed_command;
      logic               clamped;
   } rsp_item_type;

   typedef struct packed {
      logic load;
      logic step;
   } unit_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_SUM,
      ST_UPDATE
   } state_type;

endpackage

/* design/pdh_serial_mul.sv */
`timescale 1ns / 1ps

module pdh_serial_mul (
   input  logic                  clock,
   input  pdh_pkg::unit_ctl_type ctl,
   input  logic [15:0]           multiplicand,
   input  logic [15:0]           multiplier,
   output logic [31:0]           product
);
   import pdh_pkg::*;

   logic [15:0] mcand_ff, mcand_in;
   logic [15:0] hi_ff, hi_in;
   logic [15:0] lo_ff, lo_in;
   logic [17:0] partial;
   logic [17:0] sum;

   // one radix-4 digit of the multiplier per cycle
   always_comb begin
      case (lo_ff[1:0])
         2'd0:    partial = 18'd0;
         2'd1:    partial = {2'b00, mcand_ff};
         2'd2:    partial = {1'b0, mcand_ff, 1'b0};
         default: partial = {2'b00, mcand_ff} + {1'b0, mcand_ff, 1'b0};
      endcase
      sum = {2'b00, hi_ff} + partial;
   end

   always_comb begin
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      if (ctl.load) begin
         mcand_in = multiplicand;
         hi_in    = 16'd0;
         lo_in    = multiplier;
      end else if (ctl.step) begin
         hi_in = sum[17:2];
         lo_in = {sum[1:0], lo_ff[15:2]};
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign product = {hi_ff, lo_ff};

endmodule

/* design/pdh_serial_div.sv */
`timescale 1ns / 1ps

module pdh_serial_div (
   input  logic                                 clock,
   input  pdh_pkg::unit_ctl_type                ctl,
   input  logic [pdh_pkg::DividendWidth-1:0]    dividend,
   input  logic [15:0]                          divisor,
   output logic [pdh_pkg::DividendWidth-1:0]    quotient
);
   import pdh_pkg::*;

   logic [15:0]              rem_ff, rem_in;
   logic [15:0]              dvs_ff, dvs_in;
   logic [DividendWidth-1:0] quo_ff, quo_in;
   logic [16:0]              r1, r2;
   logic                     ge1, ge2;
   logic [15:0]              r1_next, r2_next;
   logic [DividendWidth-1:0] q1;

   // two restoring steps per cycle, dividend bits shift out as quotient bits shift in
   always_comb begin
      r1      = {rem_ff, quo_ff[DividendWidth-1]};
      ge1     = r1 >= {1'b0, dvs_ff};
      r1_next = ge1 ? 16'(r1 - {1'b0, dvs_ff}) : r1[15:0];
      q1      = {quo_ff[DividendWidth-2:0], ge1};
      r2      = {r1_next, q1[DividendWidth-1]};
      ge2     = r2 >= {1'b0, dvs_ff};
      r2_next = ge2 ? 16'(r2 - {1'b0, dvs_ff}) : r2[15:0];
   end

   always_comb begin
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      quo_in = quo_ff;
      if (ctl.load) begin
         rem_in = 16'd0;
         dvs_in = divisor;
         quo_in = dividend;
      end else if (ctl.step) begin
         rem_in = r2_next;
         quo_in = {q1[DividendWidth-2:0], ge2};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

/* design/pd_heading_controller.sv */
`timescale 1ns / 1ps
// pd heading controller with feed-forward
// req channel: one item of error, wall distance and elapsed time, valid/ready
// rsp channel: one item per request: turn command, speed command, clamp flag
// csr port: write enable, register index and data, to be written only while
//   idle (not enforced by the block); writes to unknown indexes are ignored
// sequence: an item is accepted only in idle; the two proportional and
//   derivative products are formed in radix-4 serial multipliers, the
//   divide by elapsed time runs in a two-bit-per-cycle restoring
//   divider, then the sum state saturates the total and the update
//   state updates the accumulator and registers the result; a new item
//   is accepted only after the update state has finished the last one
// the divider runs 18 steps of two quotient bits each
// stall: a waiting result does not block acceptance of the next item;
//   the update stage holds until the output register is free
// reset: synchronous, active high; registers return to their defaults,
//   previous error and heading accumulator clear to zero
module pd_heading_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pdh_pkg::req_item_type                req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output pdh_pkg::rsp_item_type                rsp_data,
   input  logic                                 csr_write_enable,
   input  logic [pdh_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [pdh_pkg::CsrDataWidth-1:0]     csr_write_data
);
   import pdh_pkg::*;

   state_type state_ff, state_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;

   logic [14:0] forward_speed_ff, forward_speed_in;
   logic [14:0] max_angle_ff, max_angle_in;
   logic [15:0] prop_gain_ff, prop_gain_in;
   logic [15:0] deriv_gain_ff, deriv_gain_in;
   logic [14:0] wall_setpoint_ff, wall_setpoint_in;

   logic signed [15:0] prev_error_ff, prev_error_in;
   logic signed [15:0] heading_ff, heading_in;

   logic signed [15:0] err_ff, err_in;
   logic [14:0]        dist_ff, dist_in;
   logic               dt_zero_ff, dt_zero_in;
   logic               err_neg_ff, err_neg_in;
   logic               diff_neg_ff, diff_neg_in;
   logic [15:0]        dt_ff, dt_in;
   logic signed [15:0] total_ff, total_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic rsp_free;
   logic mul_last;
   logic div_last;
   logic upd_fire;

   unit_ctl_type mul_ctl, div_ctl;

   logic [15:0]              err_mag;
   logic signed [16:0]       diff;
   logic [15:0]              diff_mag;
   logic [ProdWidth-1:0]     prod_p, prod_d;
   logic [DividendWidth-1:0] quo;

   logic signed [32:0] p_full;
   logic signed [20:0] p_term;
   logic signed [36:0] d_term;
   logic signed [15:0] ff_term;
   logic signed [38:0] total_wide;

   logic signed [17:0] acc_wide;
   logic signed [17:0] lim;
   logic signed [15:0] acc_final;
   logic               clip;

   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign mul_last   = cnt_ff == CntWidth'(MulSteps - 1);
   assign div_last   = cnt_ff == CntWidth'(DivSteps);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_accept) state_in = ST_MUL;
         ST_MUL:    if (mul_last) state_in = ST_DIV;
         ST_DIV:    if (div_last) state_in = ST_SUM;
         ST_SUM:    state_in = ST_UPDATE;
         ST_UPDATE: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready    = 1'b0;
      mul_ctl.load = 1'b0;
      mul_ctl.step = 1'b0;
      div_ctl.load = 1'b0;
      div_ctl.step = 1'b0;
      upd_fire     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            mul_ctl.load = req_valid;
         end
         ST_MUL: begin
            mul_ctl.step = 1'b1;
         end
         ST_DIV: begin
            div_ctl.load = cnt_ff == '0;
            div_ctl.step = cnt_ff != '0;
         end
         ST_SUM: begin
         end
         ST_UPDATE: begin
            upd_fire = rsp_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff + CntWidth'(1);
      if (state_in != state_ff) cnt_in = '0;
   end

   // configuration writes
   always_comb begin
      forward_speed_in = forward_speed_ff;
      max_angle_in     = max_angle_ff;
      prop_gain_in     = prop_gain_ff;
      deriv_gain_in    = deriv_gain_ff;
      wall_setpoint_in = wall_setpoint_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            RegForwardSpeed: forward_speed_in = csr_write_data[14:0];
            RegMaxAngle:     max_angle_in     = csr_write_data[14:0];
            RegPropGain:     prop_gain_in     = csr_write_data;
            RegDerivGain:    deriv_gain_in    = csr_write_data;
            RegWallSetpoint: wall_setpoint_in = csr_write_data[14:0];
            default: begin
            end
         endcase
      end
   end

   // operand capture
   always_comb begin
      err_mag  = req_data.error_value[15] ? 16'(~req_data.error_value + 16'sd1)
                                          : req_data.error_value;
      diff     = {req_data.error_value[15], req_data.error_value}
                 - {prev_error_ff[15], prev_error_ff};
      diff_mag = diff[16] ? 16'(~diff + 17'sd1) : diff[15:0];
   end

   always_comb begin
      err_in      = err_ff;
      dist_in     = dist_ff;
      dt_in       = dt_ff;
      dt_zero_in  = dt_zero_ff;
      err_neg_in  = err_neg_ff;
      diff_neg_in = diff_neg_ff;
      if (req_accept) begin
         err_in      = req_data.error_value;
         dist_in     = req_data.wall_distance;
         dt_in       = req_data.elapsed_time;
         dt_zero_in  = req_data.elapsed_time == 16'd0;
         err_neg_in  = req_data.error_value[15];
         diff_neg_in = diff[16];
      end
   end

   pdh_serial_mul u_mul_p (
      .clock        (clock),
      .ctl          (mul_ctl),
      .multiplicand (prop_gain_ff),
      .multiplier   (err_mag),
      .product      (prod_p)
   );

   pdh_serial_mul u_mul_d (
      .clock        (clock),
      .ctl          (mul_ctl),
      .multiplicand (deriv_gain_ff),
      .multiplier   (diff_mag),
      .product      (prod_d)
   );

   pdh_serial_div u_div (
      .clock    (clock),
      .ctl      (div_ctl),
      .dividend ({prod_d, 4'b0000}),
      .divisor  (dt_ff),
      .quotient (quo)
   );

   // sum of terms with saturation
   always_comb begin
      p_full  = err_neg_ff ? -$signed({1'b0, prod_p}) : $signed({1'b0, prod_p});
      p_term  = p_full[32:12];
      if (dt_zero_ff) begin
         d_term = '0;
      end else begin
         d_term = diff_neg_ff ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      end
      ff_term = $signed({1'b0, wall_setpoint_ff}) - $signed({1'b0, dist_ff});
      total_wide = $signed({{18{p_term[20]}}, p_term})
                   + $signed({{2{d_term[36]}}, d_term})
                   + $signed({{23{ff_term[15]}}, ff_term});
      total_in = total_ff;
      if (state_ff == ST_SUM) begin
         if (total_wide > 39'sd32767) begin
            total_in = 16'sh7fff;
         end else if (total_wide < -39'sd32768) begin
            total_in = 16'sh8000;
         end else begin
            total_in = total_wide[15:0];
         end
      end
   end

   // accumulator update and clamp
   always_comb begin
      acc_wide = $signed({{2{heading_ff[15]}}, heading_ff})
                 - $signed({{2{total_ff[15]}}, total_ff});
      lim      = $signed({3'b000, max_angle_ff});
      clip     = 1'b0;
      acc_final = acc_wide[15:0];
      if (acc_wide > lim) begin
         acc_final = lim[15:0];
         clip      = 1'b1;
      end else if (acc_wide < -lim) begin
         acc_final = 16'(-lim);
         clip      = 1'b1;
      end
   end

   always_comb begin
      heading_in    = heading_ff;
      prev_error_in = prev_error_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (upd_fire) begin
         heading_in                = acc_final;
         prev_error_in             = err_ff;
         rsp_data_in.turn_command  = 16'(-acc_final);
         rsp_data_in.speed_command = forward_speed_ff;
         rsp_data_in.clamped       = clip;
         rsp_valid_in              = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cnt_ff           <= '0;
         forward_speed_ff <= ForwardSpeedReset;
         max_angle_ff     <= MaxAngleReset;
         prop_gain_ff     <= PropGainReset;
         deriv_gain_ff    <= DerivGainReset;
         wall_setpoint_ff <= WallSetpointReset;
         prev_error_ff    <= '0;
         heading_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         cnt_ff           <= cnt_in;
         forward_speed_ff <= forward_speed_in;
         max_angle_ff     <= max_angle_in;
         prop_gain_ff     <= prop_gain_in;
         deriv_gain_ff    <= deriv_gain_in;
         wall_setpoint_ff <= wall_setpoint_in;
         prev_error_ff    <= prev_error_in;
         heading_ff       <= heading_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      dist_ff     <= dist_in;
      dt_ff       <= dt_in;
      dt_zero_ff  <= dt_zero_in;
      err_neg_ff  <= err_neg_in;
      diff_neg_ff <= diff_neg_in;
      total_ff    <= total_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_accept_starts_mul: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_MUL)
      else $error("accepted item did not start the multipliers");

   a_mul_to_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL && mul_last |=> state_ff == ST_DIV && cnt_ff == '0)
      else $error("multiply phase did not hand over to the divider");

   a_update_delivers: assert property (@(posedge clock) disable iff (reset)
      upd_fire |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("update did not present a result item");

   a_turn_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.turn_command != 16'sh8000)
      else $error("turn command out of range");
`endif

endmodule
